>>> hdl/sacl_pkg.sv
`default_nettype none
package sacl_pkg;

  typedef enum logic [1:0] {
    OUT_HIT   = 2'd0,
    OUT_FILL  = 2'd1,
    OUT_EVICT = 2'd2
  } outcome_e;

  localparam logic [1:0] CFG_SET_BITS    = 2'd0;
  localparam logic [1:0] CFG_WAYS_IN_USE = 2'd1;
  localparam logic [1:0] CFG_OFFSET_BITS = 2'd2;

  localparam int unsigned CfgIdxW = 2;

  typedef struct packed {
    logic        op;
    logic [63:0] address;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  outcome;
    logic [31:0] hits_so_far;
    logic [31:0] misses_so_far;
    logic [31:0] evictions_so_far;
    logic        last_of_item;
  } out_item_t;

  typedef struct packed {
    logic [CfgIdxW-1:0] index;
    logic [63:0]        data;
  } cfg_item_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_UPDATE,
    ST_OUT
  } state_e;

endpackage
`default_nettype wire

>>> hdl/set_assoc_cache_lru_tag_check.sv
`default_nettype none
// channel | direction | handshake            | payload
// in      | input     | in_valid_i/in_ready_o | sacl_pkg::in_item_t
// out     | output    | out_valid_o/out_ready_i | sacl_pkg::out_item_t
// cfg     | input     | cfg_valid_i/cfg_ready_o | sacl_pkg::cfg_item_t
//
// each access: read the set row, compare and update ranks, then show the result
// while the row is written back; the result shows after the read and update states
// a new item is taken only after the last result of the previous item is taken;
// a modify item goes through read, update and show twice, with two results
// after reset and after a write to a known config register a clearing pass
// writes every set row, one set row per cycle, and accepts no item
module set_assoc_cache_lru_tag_check #(
  parameter int unsigned MAX_SET_BITS = 6,
  parameter int unsigned MAX_WAYS     = 8
) (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       in_valid_i,
  output logic                      in_ready_o,
  input  wire sacl_pkg::in_item_t   in_item_i,
  output logic                      out_valid_o,
  input  wire                       out_ready_i,
  output sacl_pkg::out_item_t       out_item_o,
  input  wire                       cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire sacl_pkg::cfg_item_t  cfg_item_i
);
  import sacl_pkg::*;

  localparam int unsigned Sets  = 1 << MAX_SET_BITS;
  localparam int unsigned SetW  = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int unsigned RankW = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int unsigned WayW  = $clog2(MAX_WAYS + 1);
  localparam int unsigned SbW   = $clog2(MAX_SET_BITS + 1) > 0 ? $clog2(MAX_SET_BITS + 1) : 1;

  // one row holds a whole set: valid, rank and tag of every way
  typedef struct packed {
    logic             valid;
    logic [RankW-1:0] rank;
    logic [63:0]      tag;
  } line_t;
  typedef line_t [MAX_WAYS-1:0] row_t;

  row_t line_mem [Sets];
  row_t rd_row_q;
  row_t wr_row;
  logic wr_en;
  logic [SetW-1:0] wr_addr;
  logic [SetW-1:0] rd_addr;

  state_e state_q, state_d;
  logic [2:0]  set_bits_q;
  logic [3:0]  ways_q;
  logic [5:0]  offset_q;
  logic [SetW:0] clr_cnt_q, clr_cnt_d;
  logic        op_q;
  logic        second_q, second_d;
  logic [63:0] tag_q, tag_d;
  logic [SetW-1:0] set_q, set_d;
  logic [31:0] hits_q, hits_d, miss_q, miss_d, evict_q, evict_d;
  out_item_t   out_q, out_d;
  row_t        row_q, row_d;

  logic cfg_acc;
  logic cfg_clr;
  assign cfg_ready_o = (state_q == ST_IDLE) || (state_q == ST_CLEAR);
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;
  // only a write to a known register clears the store
  assign cfg_clr     = cfg_acc &&
                       (cfg_item_i.index inside {CFG_SET_BITS, CFG_WAYS_IN_USE, CFG_OFFSET_BITS});
  assign in_ready_o  = (state_q == ST_IDLE) && !cfg_valid_i;
  assign out_valid_o = (state_q == ST_OUT);
  assign out_item_o  = out_q;

  // clamped configuration
  logic [SbW-1:0] sb_eff;
  logic [WayW-1:0] ways_eff;
  always_comb begin
    if (32'(set_bits_q) > MAX_SET_BITS) sb_eff = SbW'(MAX_SET_BITS);
    else sb_eff = SbW'(set_bits_q);
    if (ways_q == 4'd0) ways_eff = WayW'(1);
    else if (32'(ways_q) > MAX_WAYS) ways_eff = WayW'(MAX_WAYS);
    else ways_eff = WayW'(ways_q);
  end

  logic [63:0] in_tag;
  logic [SetW-1:0] in_set;
  assign in_tag = in_item_i.address >> offset_q;
  always_comb begin
    in_set = '0;
    for (int b = 0; b < MAX_SET_BITS; b++) begin
      if (b < 32'(sb_eff)) in_set[b] = in_tag[b];
    end
  end

  // lookup on the row read from memory
  logic             hit;
  logic [RankW-1:0] hit_way, hit_rank, victim, victim_rank;
  logic [WayW-1:0]  nvalid;
  logic             has_empty;
  logic [RankW-1:0] empty_way;
  always_comb begin
    hit = 1'b0; hit_way = '0; hit_rank = '0; nvalid = '0;
    has_empty = 1'b0; empty_way = '0; victim = '0; victim_rank = '0;
    for (int i = 0; i < MAX_WAYS; i++) begin
      if (i < 32'(ways_eff)) begin
        if (rd_row_q[i].valid) begin
          nvalid = nvalid + 1'b1;
          if (!hit && rd_row_q[i].tag == tag_q) begin
            hit = 1'b1; hit_way = RankW'(i); hit_rank = rd_row_q[i].rank;
          end
          if (rd_row_q[i].rank >= victim_rank || !rd_row_q[victim].valid) begin
            victim = RankW'(i); victim_rank = rd_row_q[i].rank;
          end
        end else if (!has_empty) begin
          has_empty = 1'b1; empty_way = RankW'(i);
        end
      end
    end
  end

  logic [RankW-1:0] use_way;
  logic [WayW-1:0]  old_rank;
  logic [1:0]       outcome;
  row_t             upd_row;
  always_comb begin
    if (hit) begin
      use_way = hit_way; old_rank = WayW'(hit_rank); outcome = OUT_HIT;
    end else if (has_empty) begin
      use_way = empty_way; old_rank = nvalid; outcome = OUT_FILL;
    end else begin
      use_way = victim; old_rank = WayW'(victim_rank); outcome = OUT_EVICT;
    end
    upd_row = rd_row_q;
    for (int i = 0; i < MAX_WAYS; i++) begin
      if (i < 32'(ways_eff) && RankW'(i) != use_way && rd_row_q[i].valid &&
          WayW'(rd_row_q[i].rank) < old_rank) begin
        upd_row[i].rank = rd_row_q[i].rank + 1'b1;
      end
    end
    upd_row[use_way].rank  = '0;
    upd_row[use_way].valid = 1'b1;
    upd_row[use_way].tag   = tag_q;
  end

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v == '1) ? v : v + 32'd1;
  endfunction

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: if (!cfg_acc && clr_cnt_q == (SetW+1)'(Sets - 1)) state_d = ST_IDLE;
      ST_IDLE: begin
        if (cfg_clr) state_d = ST_CLEAR;
        else if (in_valid_i && in_ready_o) state_d = ST_READ;
      end
      ST_READ:   state_d = ST_UPDATE;
      ST_UPDATE: state_d = ST_OUT;
      ST_OUT: begin
        if (out_ready_i) state_d = (op_q && !second_q) ? ST_READ : ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    clr_cnt_d = clr_cnt_q;
    second_d = second_q; tag_d = tag_q; set_d = set_q;
    hits_d = hits_q; miss_d = miss_q; evict_d = evict_q;
    out_d = out_q; row_d = row_q;
    wr_en = 1'b0; wr_addr = set_q; wr_row = row_q;
    rd_addr = set_q;
    case (state_q)
      ST_CLEAR: begin
        wr_en = 1'b1; wr_addr = clr_cnt_q[SetW-1:0]; wr_row = '0;
        clr_cnt_d = cfg_acc ? '0 : clr_cnt_q + 1'b1;
      end
      ST_IDLE: begin
        clr_cnt_d = '0;
        tag_d = in_tag; set_d = in_set; second_d = 1'b0;
      end
      ST_UPDATE: begin
        row_d = upd_row;
        if (outcome == OUT_HIT) hits_d = sat_inc(hits_q);
        else miss_d = sat_inc(miss_q);
        if (outcome == OUT_EVICT) evict_d = sat_inc(evict_q);
        out_d.outcome          = outcome;
        out_d.hits_so_far      = (outcome == OUT_HIT) ? sat_inc(hits_q) : hits_q;
        out_d.misses_so_far    = (outcome != OUT_HIT) ? sat_inc(miss_q) : miss_q;
        out_d.evictions_so_far = (outcome == OUT_EVICT) ? sat_inc(evict_q) : evict_q;
        out_d.last_of_item     = !op_q || second_q;
      end
      ST_OUT: begin
        // write back while the result is shown, every cycle carries the same row
        wr_en = 1'b1;
        if (out_ready_i) second_d = 1'b1;
      end
      default: ;
    endcase
  end

  // set row memory, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) line_mem[wr_addr] <= wr_row;
    rd_row_q <= line_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      set_bits_q <= 3'd4;
      ways_q     <= 4'd1;
      offset_q   <= 6'd4;
      clr_cnt_q  <= '0;
      second_q   <= 1'b0;
      hits_q     <= '0;
      miss_q     <= '0;
      evict_q    <= '0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
      second_q  <= second_d;
      hits_q    <= hits_d;
      miss_q    <= miss_d;
      evict_q   <= evict_d;
      if (cfg_acc) begin
        case (cfg_item_i.index)
          CFG_SET_BITS:    set_bits_q <= cfg_item_i.data[2:0];
          CFG_WAYS_IN_USE: ways_q     <= cfg_item_i.data[3:0];
          CFG_OFFSET_BITS: offset_q   <= cfg_item_i.data[5:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i && in_ready_o) op_q <= in_item_i.op;
    tag_q <= tag_d;
    set_q <= set_d;
    out_q <= out_d;
    row_q <= row_d;
  end

  // the second result of a modify is always a hit
  a_modify_store_hits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT && second_q) |-> out_q.outcome == OUT_HIT)
    else $error("store half of modify missed");
  a_no_accept_during_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !in_ready_o)
    else $error("item accepted while clearing");
  a_hits_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ##1 (hits_q >= $past(hits_q)))
    else $error("hit count went backwards");
  a_out_follows_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == ST_UPDATE)
    else $error("result without update");

endmodule
`default_nettype wire

>>> test/set_assoc_cache_lru_tag_check_test.sv
`timescale 1ns / 1ps
`default_nettype none
module set_assoc_cache_lru_tag_check_test;
  import sacl_pkg::*;

  localparam int unsigned MaxSetBits = 6;
  localparam int unsigned MaxWays    = 8;
  localparam int unsigned LineCount  = (1 << MaxSetBits) * MaxWays;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned RandomItems = 450;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_item;
  logic      cfg_valid;
  logic      cfg_ready;
  cfg_item_t cfg_item;

  set_assoc_cache_lru_tag_check u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_item_i  (cfg_item)
  );

  // shadow copy of the tag store, lru ranks and running counts
  logic [2:0]  shadow_set_bits;
  logic [3:0]  shadow_ways;
  logic [5:0]  shadow_offset;
  logic        line_valid_q [LineCount];
  logic [63:0] line_tag_q   [LineCount];
  logic [2:0]  line_rank_q  [LineCount];
  logic [31:0] hit_count;
  logic [31:0] miss_count;
  logic [31:0] evict_count;

  out_item_t   expected_results[$];
  int unsigned mismatches;
  int unsigned cycle_count;
  int unsigned burst_left;

  // address pool that makes sets collide so hits and evictions show up
  logic [63:0] tag_pool[16];

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [31:0] bump(logic [31:0] v);
    return (v == 32'hffff_ffff) ? v : v + 32'd1;
  endfunction

  function automatic void clear_lines();
    for (int i = 0; i < LineCount; i++) begin
      line_valid_q[i] = 1'b0;
      line_rank_q[i]  = '0;
    end
  endfunction

  // make way w the most recently used one, aging those younger than it was
  function automatic void promote(int base, int ways, int w, int old_rank);
    for (int i = 0; i < ways; i++) begin
      if (i != w && line_valid_q[base+i] && line_rank_q[base+i] < old_rank)
        line_rank_q[base+i] = line_rank_q[base+i] + 3'd1;
    end
    line_rank_q[base+w] = '0;
  endfunction

  function automatic outcome_e cache_access(logic [63:0] address);
    int          sb;
    int          ways;
    logic [63:0] tag;
    int          base;
    int          nvalid;
    int          victim;
    int          empty;
    int          k;
    sb     = (shadow_set_bits > MaxSetBits) ? MaxSetBits : shadow_set_bits;
    ways   = (shadow_ways == 0) ? 1 : ((shadow_ways > MaxWays) ? MaxWays : shadow_ways);
    tag    = address >> shadow_offset;
    base   = int'(tag & ((64'd1 << sb) - 64'd1)) * MaxWays;
    nvalid = 0;
    victim = 0;
    empty  = MaxWays;
    for (int i = 0; i < ways; i++) begin
      k = base + i;
      if (line_valid_q[k]) begin
        nvalid++;
        if (line_tag_q[k] == tag) begin
          promote(base, ways, i, line_rank_q[k]);
          hit_count = bump(hit_count);
          return OUT_HIT;
        end
        if (line_rank_q[k] >= line_rank_q[base+victim] || !line_valid_q[base+victim])
          victim = i;
      end else if (empty == MaxWays) begin
        empty = i;
      end
    end
    miss_count = bump(miss_count);
    if (empty != MaxWays) begin
      line_valid_q[base+empty] = 1'b1;
      line_tag_q[base+empty]   = tag;
      promote(base, ways, empty, nvalid);
      return OUT_FILL;
    end
    evict_count = bump(evict_count);
    line_tag_q[base+victim] = tag;
    promote(base, ways, victim, line_rank_q[base+victim]);
    return OUT_EVICT;
  endfunction

  function automatic void queue_result(outcome_e oc, logic last);
    out_item_t r;
    r.outcome          = oc;
    r.hits_so_far      = hit_count;
    r.misses_so_far    = miss_count;
    r.evictions_so_far = evict_count;
    r.last_of_item     = last;
    expected_results.push_back(r);
  endfunction

  // a modify item is a load then a store, two results
  function automatic void predict_item(logic op, logic [63:0] address);
    queue_result(cache_access(address), !op);
    if (op) queue_result(cache_access(address), 1'b1);
  endfunction

  // all tasks start and end in the time step of a rising edge
  task automatic send_access(logic op, logic [63:0] address);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 14);
    end
    burst_left--;
    in_valid      <= 1'b1;
    in_item.op      <= op;
    in_item.address <= address;
    do @(posedge clk); while (!in_ready);
    predict_item(op, address);
  endtask

  task automatic write_reg(logic [1:0] index, logic [63:0] data);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_valid      <= 1'b1;
    cfg_item.index <= index;
    cfg_item.data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (index)
      CFG_SET_BITS:    shadow_set_bits = data[2:0];
      CFG_WAYS_IN_USE: shadow_ways     = data[3:0];
      CFG_OFFSET_BITS: shadow_offset   = data[5:0];
      default: ;
    endcase
    clear_lines();
  endtask

  task automatic set_config(int sb, int ways, int off);
    // random upper data bits must be ignored
    write_reg(CFG_SET_BITS, {$urandom, $urandom} & ~64'h7 | 64'(sb));
    write_reg(CFG_WAYS_IN_USE, {$urandom, $urandom} & ~64'hf | 64'(ways));
    write_reg(CFG_OFFSET_BITS, {$urandom, $urandom} & ~64'h3f | 64'(off));
  endtask

  function automatic void fill_tag_pool();
    logic [63:0] high_part;
    high_part = {$urandom, $urandom} & ~64'hfff;
    for (int i = 0; i < 16; i++)
      tag_pool[i] = high_part | (64'($urandom_range(0, 11)) << 6) | 64'($urandom_range(0, 1));
  endfunction

  // mostly pooled tags with random offset bits, some fully random addresses
  function automatic logic [63:0] pick_address();
    logic [63:0] offset_mask;
    if ($urandom_range(0, 4) == 0) return {$urandom, $urandom};
    offset_mask = (64'd1 << shadow_offset) - 64'd1;
    return (tag_pool[$urandom_range(0, 15)] << shadow_offset)
           | ({$urandom, $urandom} & offset_mask);
  endfunction

  // reset values: 16 sets, one way, 16 byte lines
  task automatic test_reset_config();
    send_access(1'b0, 64'h0);
    send_access(1'b0, 64'hf);
    send_access(1'b0, 64'h100);
    send_access(1'b1, 64'h0);
    send_access(1'b0, 64'hffff_ffff_ffff_ffff);
  endtask

  // lru order in one fully associative set of four ways
  task automatic test_lru_order();
    set_config(0, 4, 0);
    for (int i = 1; i <= 4; i++) send_access(1'b0, 64'(i));
    send_access(1'b0, 64'd1);
    send_access(1'b0, 64'd5);
    send_access(1'b1, 64'd2);
    send_access(1'b0, 64'd3);
    send_access(1'b0, 64'd1);
  endtask

  // out of range set count and way count, zero and large offsets
  task automatic test_config_extremes();
    set_config(7, 15, 63);
    send_access(1'b0, 64'hffff_ffff_ffff_ffff);
    send_access(1'b1, 64'h8000_0000_0000_0000);
    send_access(1'b0, 64'h0);
    set_config(0, 0, 0);
    send_access(1'b0, 64'h1234);
    send_access(1'b0, 64'h1235);
    send_access(1'b1, 64'h1234);
    set_config(6, 8, 33);
    send_access(1'b0, 64'h5555_5555_5555_5555);
    send_access(1'b0, 64'haaaa_aaaa_aaaa_aaaa);
  endtask

  task automatic test_random_traffic();
    int per_phase;
    per_phase = RandomItems / 9;
    for (int phase = 0; phase < 9; phase++) begin
      case (phase)
        0:       set_config(1, 2, 4);
        1:       set_config(0, 8, 0);
        2:       set_config(6, 1, 32);
        3:       set_config(2, 3, 6);
        4:       set_config(7, 12, 5);
        default: set_config($urandom_range(0, 7), $urandom_range(0, 15), $urandom_range(0, 63));
      endcase
      fill_tag_pool();
      repeat (per_phase) send_access($urandom_range(0, 3) == 0, pick_address());
    end
  endtask

  // receiver: phases of no stall, periodic stall and random stall
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready   <= 1'b0;
      cycle_count <= 0;
    end else begin
      cycle_count <= cycle_count + 1;
      case ((cycle_count / 250) % 3)
        0:       out_ready <= 1'b1;
        1:       out_ready <= (cycle_count % 7) > 2;
        default: out_ready <= $urandom_range(0, 2) != 0;
      endcase
      if (cycle_count > CycleLimit) begin
        $display("** set_assoc_cache_lru_tag_check: FAILED **");
        $finish;
      end
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected item %p", out_item);
        end else begin
          out_item_t want;
          want = expected_results.pop_front();
          if (out_item.outcome !== want.outcome
              || out_item.hits_so_far !== want.hits_so_far
              || out_item.misses_so_far !== want.misses_so_far
              || out_item.evictions_so_far !== want.evictions_so_far
              || out_item.last_of_item !== want.last_of_item) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, out_item);
          end
        end
      end
    end
  end

  initial begin
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_item         = '0;
    cfg_valid       = 1'b0;
    cfg_item        = '0;
    mismatches      = 0;
    burst_left      = 0;
    shadow_set_bits = 3'd4;
    shadow_ways     = 4'd1;
    shadow_offset   = 6'd4;
    hit_count       = '0;
    miss_count      = '0;
    evict_count     = '0;
    clear_lines();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_config();
    test_lru_order();
    test_config_extremes();
    test_random_traffic();

    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0)
      $display("** set_assoc_cache_lru_tag_check: PASSED **");
    else
      $display("** set_assoc_cache_lru_tag_check: FAILED **");
    $finish;
  end

endmodule
`default_nettype wire
